/* design/rws_pkg.sv */
// Shared constants for the roulette wheel selection unit.
`timescale 1ns / 1ps
package rws_pkg;
	localparam int MAX_ENTRIES = 64;
	localparam int WEIGHT_BITS = 16;
	localparam int IN_BITS     = 16;
	localparam int DRAW_BITS   = 16;
	localparam int IDX_BITS    = $clog2(MAX_ENTRIES);
	localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);
	localparam int TOTAL_BITS  = WEIGHT_BITS + IDX_BITS;
	localparam int TARGET_BITS = TOTAL_BITS + DRAW_BITS;
endpackage

/* design/roulette_wheel_selection_unit.sv */
// Roulette wheel selection: top level with weight store and prefix scan.
//
// Input channel (in_valid / in_stall): one word per weight. The word with
// is_last set closes the list and carries the draw. While in_stall is low,
// weights load one per cycle; a word to a full store is dropped and flagged.
// Output channel (out_valid / out_stall): one word per list, giving the
// smallest index whose prefix sum * 65536 reaches draw * total, and whether
// any weight of that list was dropped. A zero draw or zero total gives 0.
// After the last word, a zero draw or total skips the scan; otherwise the
// scan walks the list from index 0 and stops at the chosen index, reading one
// stored weight per cycle through the single read port of the weight RAM.
// in_stall is high from the last word until the result enters the output
// register, so the next list waits for both the scan and the output.
// While out_stall holds a result, new weights still load; a finished scan
// waits for the output register to free before taking the next list.
// Reset clears the count, total, flag and output valid; the RAM is not
// cleared, since only entries written in the current list are read.
`timescale 1ns / 1ps
module roulette_wheel_selection_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rws_pkg::IN_BITS-1:0]   weight,
	input  logic                          is_last,
	input  logic [rws_pkg::DRAW_BITS-1:0] draw,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rws_pkg::IDX_BITS-1:0]  chosen_index,
	output logic                          overflowed
);
	import rws_pkg::*;

	typedef enum logic [1:0] {S_LOAD, S_MUL, S_SCAN, S_PUSH} state_t;

	state_t                  state_q;
	logic [CNT_BITS-1:0]     count_q;
	logic [TOTAL_BITS-1:0]   total_q;
	logic                    ovf_q;
	logic [IDX_BITS-1:0]     chk_q;
	logic [IDX_BITS-1:0]     res_q;
	logic                    out_valid_q;
	logic [IDX_BITS-1:0]     out_idx_q;
	logic                    out_ovf_q;
	logic [DRAW_BITS-1:0]    draw_q;
	logic [TARGET_BITS-1:0]  target_q;
	logic [TOTAL_BITS-1:0]   prefix_q;

	logic                    accept;
	logic                    has_room;
	logic [31:0]             w_ext;
	logic [WEIGHT_BITS-1:0]  w;
	logic [IDX_BITS-1:0]     rd_addr;
	logic [WEIGHT_BITS-1:0]  rd_data;
	logic [TOTAL_BITS-1:0]   sum;
	logic                    hit;
	logic [IDX_BITS-1:0]     last_idx;
	logic [TARGET_BITS-1:0]  product;
	logic                    out_free;

	assign in_stall  = (state_q != S_LOAD);
	assign accept    = in_valid && !in_stall;
	assign has_room  = (count_q < CNT_BITS'(MAX_ENTRIES));
	assign w_ext     = {{(32 - IN_BITS){1'b0}}, weight};
	assign w         = w_ext[WEIGHT_BITS-1:0];
	assign rd_addr   = (state_q == S_MUL) ? '0 : chk_q + IDX_BITS'(1);
	assign sum       = prefix_q + TOTAL_BITS'(rd_data);
	assign hit       = ({sum, {DRAW_BITS{1'b0}}} >= target_q);
	assign last_idx  = IDX_BITS'(count_q - CNT_BITS'(1));
	assign product   = TARGET_BITS'(draw_q) * TARGET_BITS'(total_q);
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign chosen_index = out_idx_q;
	assign overflowed   = out_ovf_q;

	rws_ram #(
		.WIDTH(WEIGHT_BITS),
		.DEPTH(MAX_ENTRIES)
	) u_store (
		.clk    (clk),
		.wr_en  (accept && has_room),
		.wr_addr(count_q[IDX_BITS-1:0]),
		.wr_data(w),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			count_q     <= '0;
			total_q     <= '0;
			ovf_q       <= 1'b0;
			chk_q       <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (state_q == S_PUSH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (has_room) begin
							count_q <= count_q + CNT_BITS'(1);
							total_q <= total_q + TOTAL_BITS'(w);
						end else begin
							ovf_q <= 1'b1;
						end
						if (is_last) begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					chk_q <= '0;
					if (draw_q == '0 || total_q == '0) begin
						res_q   <= '0;
						state_q <= S_PUSH;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit || chk_q == last_idx) begin
						res_q   <= chk_q;
						state_q <= S_PUSH;
					end else begin
						chk_q <= chk_q + IDX_BITS'(1);
					end
				end
				S_PUSH: begin
					if (out_free) begin
						out_idx_q   <= res_q;
						out_ovf_q   <= ovf_q;
						count_q     <= '0;
						total_q     <= '0;
						ovf_q       <= 1'b0;
						state_q     <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_last) begin
			draw_q <= draw;
		end
		if (state_q == S_MUL) begin
			target_q <= product;
			prefix_q <= '0;
		end else if (state_q == S_SCAN) begin
			prefix_q <= sum;
		end
	end
endmodule

/* design/rws_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module rws_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

/* design/rws_checker.sv */
// Port-level checks for the roulette wheel selection unit, bound to the top.
`timescale 1ns / 1ps
module rws_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          is_last,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [rws_pkg::IDX_BITS-1:0]  chosen_index,
	input logic                          overflowed
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(chosen_index) && $stable(overflowed))
		else $error("stalled result word changed");

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && is_last |=> in_stall)
		else $error("input not held off after last word");

	a_release_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> out_valid)
		else $error("input released without a result");

	a_result_opens_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result issued while input still held off");
endmodule

bind roulette_wheel_selection_unit rws_checker u_rws_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.is_last     (is_last),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.chosen_index(chosen_index),
	.overflowed  (overflowed)
);
